[rtl/qfs_pkg.sv]
// Shared types, codes and constants of the quoted field splitter.
`default_nettype none

package qfs_pkg;

   localparam int OUT_W          = 13;
   localparam int MAX_LINE_BYTES = 4096;
   localparam int RSP_DEPTH      = 8;
   localparam int MAX_WORDS      = 3;

   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] NUL_BYTE  = 8'h00;

   localparam logic [OUT_W-1:0] FIELD_COUNT_MAX = {OUT_W{1'b1}};

   // register indexes of the write port
   localparam logic [1:0] CSR_SEPARATOR    = 2'd0;
   localparam logic [1:0] CSR_QUOTE_CHAR   = 2'd1;
   localparam logic [1:0] CSR_QUOTE_MODE   = 2'd2;
   localparam logic [1:0] CSR_STRIP_SPACES = 2'd3;

   // quote modes
   localparam logic [1:0] QM_NONE    = 2'd0;
   localparam logic [1:0] QM_LONE    = 2'd1;
   localparam logic [1:0] QM_ANY     = 2'd2;
   localparam logic [1:0] QM_DOUBLED = 2'd3;

   localparam logic KIND_FIELD = 1'b0;
   localparam logic KIND_EOL   = 1'b1;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_UNCLOSED = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   localparam logic [7:0] SEPARATOR_RESET  = 8'd44;
   localparam logic [7:0] QUOTE_CHAR_RESET = 8'd34;

   typedef struct packed {
      logic [7:0] separator;
      logic [7:0] quote_char;
      logic [1:0] quote_mode;
      logic       strip_spaces;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [OUT_W-1:0] field_start;
      logic [OUT_W-1:0] field_end;
      logic [OUT_W-1:0] field_number;
      logic [1:0]       error_code;
   } rsp_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

`default_nettype wire

[rtl/quoted_field_splitter.sv]
// Top level of the quoted field splitter: byte parser, line state and result queue.
// Latency: a byte's results are decided when the next byte of the line arrives (or at
//    line end) and can leave on rsp_ the cycle after that accepting edge.
// Throughput: one byte per cycle; a line end yields up to three words, so req_ready
//    drops while fewer than three result queue slots are free (queue depth RSP_DEPTH).
// Reset (synchronous, active high): restore register defaults, clear line state and
//    empty the result queue; no clearing pass is needed.
`default_nettype none

module quoted_field_splitter #(
   parameter int MAX_LINE_BYTES = qfs_pkg::MAX_LINE_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_line_byte,
   input  wire logic        req_line_end,
   // result words
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [12:0]      rsp_field_start,
   output logic [12:0]      rsp_field_end,
   output logic [12:0]      rsp_field_number,
   output logic [1:0]       rsp_error_code,
   // register writes
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int OW     = qfs_pkg::OUT_W;
   // position never passes MAX_LINE_BYTES: the line is dropped once it gets there
   localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);
   localparam int DEPTH  = qfs_pkg::RSP_DEPTH;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int NCAND  = 4;
   localparam int NC_W   = $clog2(NCAND + 1);

   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE_BYTES);
   localparam logic [CNT_W-1:0] ROOM    = CNT_W'(DEPTH - qfs_pkg::MAX_WORDS);

   typedef struct packed {
      logic             in_quote;
      logic             skip_next;
      logic             field_open;
      logic             skipping_lead;
      logic             discarding;
      logic [7:0]       before_held;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] open_start;
      logic [POS_W-1:0] kept_end;
      logic [OW-1:0]    field_count;
   } line_state_type;

   typedef struct packed {
      line_state_type    st;
      logic              fire;
      qfs_pkg::rsp_type  rsp;
   } step_type;

   //------------------------------------------------------------------
   // Helpers
   //------------------------------------------------------------------
   function automatic line_state_type clear_state();
      line_state_type s;
      s               = '0;
      s.skipping_lead = 1'b1;
      return s;
   endfunction

   function automatic logic [OW-1:0] bump_count(logic [OW-1:0] n);
      return (n < qfs_pkg::FIELD_COUNT_MAX) ? n + OW'(1) : n;
   endfunction

   // Advance the line state by one byte c; nx/nv give the byte after it, if any.
   function automatic step_type do_byte(line_state_type s, qfs_pkg::cfg_type cfg,
                                        logic [7:0] c, logic [7:0] nx, logic nv);
      step_type r;
      logic     ws;
      logic     dbl;
      r      = '0;
      r.st   = s;
      ws     = qfs_pkg::is_ws(c);
      dbl    = nv && (nx == cfg.quote_char);
      if (s.discarding) begin
         // drop the rest of the line
      end else if (s.position >= POS_MAX) begin
         r.fire             = 1'b1;
         r.rsp.kind         = qfs_pkg::KIND_FIELD;
         r.rsp.field_start  = s.field_open ? OW'(s.open_start) : OW'(s.position);
         r.rsp.field_end    = OW'(POS_MAX);
         r.rsp.field_number = s.field_count;
         r.rsp.error_code   = qfs_pkg::ERR_TOO_LONG;
         r.st.discarding    = 1'b1;
      end else if (s.skip_next) begin
         // second byte of a doubled quote
         r.st.skip_next   = 1'b0;
         if (!ws) r.st.kept_end = s.position + POS_W'(1);
         r.st.before_held = c;
         r.st.position    = s.position + POS_W'(1);
      end else if (!s.field_open && cfg.strip_spaces && s.skipping_lead && ws) begin
         r.st.position = s.position + POS_W'(1);
      end else begin
         if (!s.field_open) begin
            r.st.field_open    = 1'b1;
            r.st.skipping_lead = 1'b0;
            r.st.open_start    = s.position;
            r.st.kept_end      = s.position;
            r.st.before_held   = 8'd0;
            r.st.in_quote      = 1'b0;
         end
         if ((!r.st.in_quote && (c == cfg.separator)) || (c == qfs_pkg::NUL_BYTE)) begin
            r.fire             = 1'b1;
            r.rsp.kind         = qfs_pkg::KIND_FIELD;
            r.rsp.field_start  = OW'(r.st.open_start);
            r.rsp.field_number = r.st.field_count;
            if (r.st.in_quote) begin
               r.rsp.field_end  = OW'(s.position);
               r.rsp.error_code = qfs_pkg::ERR_UNCLOSED;
               r.st.discarding  = 1'b1;
            end else begin
               r.rsp.field_end    = cfg.strip_spaces ? OW'(r.st.kept_end) : OW'(s.position);
               r.rsp.error_code   = qfs_pkg::ERR_OK;
               r.st.field_count   = bump_count(r.st.field_count);
               r.st.field_open    = 1'b0;
               r.st.skipping_lead = 1'b1;
               r.st.position      = s.position + POS_W'(1);
            end
         end else begin
            if (c == cfg.quote_char) begin
               case (cfg.quote_mode)
                  qfs_pkg::QM_LONE: begin
                     if (dbl) r.st.skip_next = 1'b1;
                     else if (r.st.before_held != qfs_pkg::BACKSLASH)
                        r.st.in_quote = !r.st.in_quote;
                  end
                  qfs_pkg::QM_ANY: begin
                     r.st.in_quote = !r.st.in_quote;
                  end
                  qfs_pkg::QM_DOUBLED: begin
                     if (dbl) begin
                        r.st.in_quote  = !r.st.in_quote;
                        r.st.skip_next = 1'b1;
                     end
                  end
                  default: begin
                     // no quoting
                  end
               endcase
            end
            if (!ws) r.st.kept_end = s.position + POS_W'(1);
            r.st.before_held = c;
            r.st.position    = s.position + POS_W'(1);
         end
      end
      return r;
   endfunction

   //------------------------------------------------------------------
   // Registers
   //------------------------------------------------------------------
   qfs_pkg::cfg_type  cfg_ff;
   line_state_type    state_ff, state_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;

   qfs_pkg::rsp_type  fifo_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              accept;
   logic              pop;
   step_type          p_held, p_last, p_fin;
   logic              cand_fire [NCAND];
   qfs_pkg::rsp_type  cand_rsp  [NCAND];
   logic [PTR_W-1:0]  cand_idx  [NCAND];
   logic [NC_W-1:0]   push_cnt;

   //------------------------------------------------------------------
   // Byte parser: the held byte first (it now sees its successor), then
   // at line end the incoming byte, the open field and the end marker.
   //------------------------------------------------------------------
   assign accept = req_valid && req_ready;

   always_comb begin
      p_held = '0;
      p_held.st = state_ff;
      if (held_valid_ff)
         p_held = do_byte(state_ff, cfg_ff, held_byte_ff, req_line_byte, 1'b1);

      p_last = do_byte(p_held.st, cfg_ff, req_line_byte, 8'd0, 1'b0);

      // close the field still open at line end
      p_fin    = '0;
      p_fin.st = p_last.st;
      if (!p_last.st.discarding && p_last.st.field_open) begin
         p_fin.fire             = 1'b1;
         p_fin.rsp.kind         = qfs_pkg::KIND_FIELD;
         p_fin.rsp.field_start  = OW'(p_last.st.open_start);
         p_fin.rsp.field_number = p_last.st.field_count;
         if (p_last.st.in_quote) begin
            p_fin.rsp.field_end  = OW'(p_last.st.position);
            p_fin.rsp.error_code = qfs_pkg::ERR_UNCLOSED;
         end else begin
            p_fin.rsp.field_end   = cfg_ff.strip_spaces ? OW'(p_last.st.kept_end)
                                                        : OW'(p_last.st.position);
            p_fin.rsp.error_code  = qfs_pkg::ERR_OK;
            p_fin.st.field_count  = bump_count(p_last.st.field_count);
         end
      end

      cand_fire[0] = accept && p_held.fire;
      cand_rsp[0]  = p_held.rsp;
      cand_fire[1] = accept && req_line_end && p_last.fire;
      cand_rsp[1]  = p_last.rsp;
      cand_fire[2] = accept && req_line_end && p_fin.fire;
      cand_rsp[2]  = p_fin.rsp;
      cand_fire[3] = accept && req_line_end;
      cand_rsp[3]  = '{kind: qfs_pkg::KIND_EOL, field_start: '0, field_end: '0,
                       field_number: p_fin.st.field_count,
                       error_code: qfs_pkg::ERR_OK};

      // pack the firing words behind the write pointer
      push_cnt = '0;
      for (int i = 0; i < NCAND; i++) begin
         cand_idx[i] = wr_ptr_ff + PTR_W'(push_cnt);
         if (cand_fire[i]) push_cnt = push_cnt + NC_W'(1);
      end

      state_in      = state_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (req_line_end) begin
            state_in      = clear_state();
            held_valid_in = 1'b0;
         end else begin
            state_in      = p_held.st;
            held_byte_in  = req_line_byte;
            held_valid_in = 1'b1;
         end
      end
   end

   //------------------------------------------------------------------
   // Result queue
   //------------------------------------------------------------------
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   // hold off the next byte unless a line end's three words would fit
   assign req_ready = (count_ff <= ROOM);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   assign rsp_kind         = fifo_ff[rd_ptr_ff].kind;
   assign rsp_field_start  = fifo_ff[rd_ptr_ff].field_start;
   assign rsp_field_end    = fifo_ff[rd_ptr_ff].field_end;
   assign rsp_field_number = fifo_ff[rd_ptr_ff].field_number;
   assign rsp_error_code   = fifo_ff[rd_ptr_ff].error_code;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NCAND; i++) begin
         if (cand_fire[i]) fifo_ff[cand_idx[i]] <= cand_rsp[i];
      end
   end

   //------------------------------------------------------------------
   // Control state and registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator    <= qfs_pkg::SEPARATOR_RESET;
         cfg_ff.quote_char   <= qfs_pkg::QUOTE_CHAR_RESET;
         cfg_ff.quote_mode   <= qfs_pkg::QM_NONE;
         cfg_ff.strip_spaces <= 1'b0;
         state_ff            <= clear_state();
         held_byte_ff        <= 8'd0;
         held_valid_ff       <= 1'b0;
         wr_ptr_ff           <= '0;
         rd_ptr_ff           <= '0;
         count_ff            <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               qfs_pkg::CSR_SEPARATOR:    cfg_ff.separator    <= csr_wdata;
               qfs_pkg::CSR_QUOTE_CHAR:   cfg_ff.quote_char   <= csr_wdata;
               qfs_pkg::CSR_QUOTE_MODE:   cfg_ff.quote_mode   <= csr_wdata[1:0];
               qfs_pkg::CSR_STRIP_SPACES: cfg_ff.strip_spaces <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         state_ff      <= state_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   // the queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overfilled");

   // a line end leaves no held byte and always queues its end marker
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      (accept && req_line_end) |=> (!held_valid_ff && (count_ff != '0)))
      else $error("line end left a held byte or no end marker");

   // while a line is being dropped and no byte arrives, line state holds
   a_discard_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff.discarding && !accept) |=> $stable(state_ff))
      else $error("line state moved while discarding");

endmodule

`default_nettype wire
